// ===== rtl/bdsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_pkg
// Shared constants and codes of the breakable damped spring force block.
// ----------------------------------------------------------------------------
package bdsf_pkg;

  // fixed point position of every Q value except the stretch limit
  localparam int FRAC_BITS = 16;

  localparam int POS_W  = 32;  // positions, velocities, forces
  localparam int REST_W = 31;  // rest length
  localparam int CFG_W  = 32;  // widest register
  localparam int IDX_W  = 2;   // register index

  localparam logic [31:0] STIFF_RST  = 32'(50 << FRAC_BITS);
  localparam logic [31:0] DAMP_RST   = 32'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [15:0] STRCH_RST  = 16'd9830;
  localparam logic [31:0] MINLEN_RST = 32'(10 << FRAC_BITS);

  typedef enum logic [IDX_W-1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_MAX_STRETCH = 2'd2,
    CFG_MIN_LENGTH  = 2'd3
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== rtl/bdsf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_in_if
// Spring item channel: end positions, velocities and rest length.
// ----------------------------------------------------------------------------
interface bdsf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bdsf_pkg::POS_W-1:0]   first_x;
  logic signed [bdsf_pkg::POS_W-1:0]   first_y;
  logic signed [bdsf_pkg::POS_W-1:0]   second_x;
  logic signed [bdsf_pkg::POS_W-1:0]   second_y;
  logic signed [bdsf_pkg::POS_W-1:0]   first_vx;
  logic signed [bdsf_pkg::POS_W-1:0]   first_vy;
  logic signed [bdsf_pkg::POS_W-1:0]   second_vx;
  logic signed [bdsf_pkg::POS_W-1:0]   second_vy;
  logic        [bdsf_pkg::REST_W-1:0]  rest_length;

  modport source (
    output valid, first_x, first_y, second_x, second_y,
    output first_vx, first_vy, second_vx, second_vy, rest_length,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y,
    input  first_vx, first_vy, second_vx, second_vy, rest_length,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/bdsf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_out_if
// Result item channel: force on the second end, break flag, distance.
// ----------------------------------------------------------------------------
interface bdsf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bdsf_pkg::POS_W-1:0]  force_x;
  logic signed [bdsf_pkg::POS_W-1:0]  force_y;
  logic                               broken;
  logic        [bdsf_pkg::POS_W-1:0]  distance;

  modport source (output valid, force_x, force_y, broken, distance, input ready);
  modport sink (input valid, force_x, force_y, broken, distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdsf_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module bdsf_sqrt_cell #(
  parameter int RW = 33,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RW+1:0]     rem_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [RW-1:0]     root_i,
  input  logic [SW-1:0]     sb_i,
  output logic              vld_o,
  output logic [RW+1:0]     rem_o,
  output logic [2*RW-1:0]   rad_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     sb_o
);
  localparam int TW = RW + 4;

  logic [TW-1:0] trial, test, diff;
  logic          ge;
  logic [RW+1:0] rem_d;

  always_comb begin
    trial = {rem_i, rad_i[2*RW-1 -: 2]};
    test  = TW'({root_i, 2'b01});
    diff  = trial - test;
    ge    = (trial >= test);
    rem_d = ge ? diff[RW+1:0] : trial[RW+1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      root_o <= {root_i[RW-2:0], ge};
      sb_o   <= sb_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bdsf_sqrt_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_sqrt_chain
// Row of square root cells, one root bit per cell, floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module bdsf_sqrt_chain #(
  parameter int RW = 33,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SW-1:0]     sb_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     sb_o
);
  logic              vld  [RW+1];
  logic [RW+1:0]     rem  [RW+1];
  logic [2*RW-1:0]   rad  [RW+1];
  logic [RW-1:0]     root [RW+1];
  logic [SW-1:0]     sb   [RW+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = '0;
  assign rad[0]  = rad_i;
  assign root[0] = '0;
  assign sb[0]   = sb_i;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    bdsf_sqrt_cell #(.RW(RW), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld[i]),
      .rem_i  (rem[i]),
      .rad_i  (rad[i]),
      .root_i (root[i]),
      .sb_i   (sb[i]),
      .vld_o  (vld[i+1]),
      .rem_o  (rem[i+1]),
      .rad_o  (rad[i+1]),
      .root_o (root[i+1]),
      .sb_o   (sb[i+1])
    );
  end

  assign vld_o  = vld[RW];
  assign root_o = root[RW];
  assign sb_o   = sb[RW];
endmodule
`default_nettype wire

// ===== rtl/bdsf_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_div_cell
// One restoring division step: one dividend bit in, one quotient bit out.
// ----------------------------------------------------------------------------
module bdsf_div_cell #(
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [DW-1:0]  d_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [QW-1:0]  lo_i,
  input  logic [SW-1:0]  sb_i,
  output logic           vld_o,
  output logic [DW-1:0]  d_o,
  output logic [DW-1:0]  rem_o,
  output logic [QW-1:0]  lo_o,
  output logic [SW-1:0]  sb_o
);
  logic [DW:0]   trial, diff;
  logic          ge;
  logic [DW-1:0] rem_d;

  // low bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    trial = {rem_i, lo_i[QW-1]};
    diff  = trial - {1'b0, d_i};
    ge    = (trial >= {1'b0, d_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o   <= d_i;
      rem_o <= rem_d;
      lo_o  <= {lo_i[QW-2:0], ge};
      sb_o  <= sb_i;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bdsf_div_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdsf_div_chain
// Row of division cells. Needs rem_i < d_i; gives QW quotient bits.
// ----------------------------------------------------------------------------
module bdsf_div_chain #(
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [DW-1:0]  d_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [QW-1:0]  lo_i,
  input  logic [SW-1:0]  sb_i,
  output logic           vld_o,
  output logic [DW-1:0]  d_o,
  output logic [DW-1:0]  rem_o,
  output logic [QW-1:0]  q_o,
  output logic [SW-1:0]  sb_o
);
  logic          vld [QW+1];
  logic [DW-1:0] d   [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] lo  [QW+1];
  logic [SW-1:0] sb  [QW+1];

  assign vld[0] = vld_i;
  assign d[0]   = d_i;
  assign rem[0] = rem_i;
  assign lo[0]  = lo_i;
  assign sb[0]  = sb_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    bdsf_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld[i]),
      .d_i    (d[i]),
      .rem_i  (rem[i]),
      .lo_i   (lo[i]),
      .sb_i   (sb[i]),
      .vld_o  (vld[i+1]),
      .d_o    (d[i+1]),
      .rem_o  (rem[i+1]),
      .lo_o   (lo[i+1]),
      .sb_o   (sb[i+1])
    );
  end

  assign vld_o = vld[QW];
  assign d_o   = d[QW];
  assign rem_o = rem[QW];
  assign q_o   = lo[QW];
  assign sb_o  = sb[QW];
endmodule
`default_nettype wire

// ===== rtl/breakable_damped_spring_force_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// breakable_damped_spring_force_top
// Damped, breakable 2D spring force in signed Q16.16, one spring per item.
// ----------------------------------------------------------------------------
// Takes one spring per cycle while the output buffer has room and returns one
// result item per spring. The path is a 3-stage front end, a 33-cell square
// root row, 3 stages for stretch, break test and stiffness term, a 34-cell and
// a 32-cell divider row for the damping term, 6 stages of sums and partial
// products, a pair of 32-cell divider rows (one per axis) for the projection
// onto the unit direction, and the output register. The whole pipeline moves
// together; it stops only when the two-entry output buffer is full, so one
// result can wait while the next spring is still taken. The user must write
// registers only while no item is in flight; the block does not enforce this.
// The register index is 2 bits wide, so every index is a register.
// ----------------------------------------------------------------------------
module breakable_damped_spring_force_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdsf_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [bdsf_pkg::CFG_W-1:0]      cfg_data_i,
  bdsf_in_if.sink                         spring_i,
  bdsf_out_if.source                      result_o
);
  localparam int F   = bdsf_pkg::FRAC_BITS;
  localparam int T_W = 68 - F;       // |T2| < 2^68, shifted down by F
  localparam int N_W = T_W + 33;     // |T| * |d| before the last division

  // --------------------------------------------------------------------------
  // stage payloads
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic signed [32:0] dx, dy, rvx, rvy;
    logic [30:0]        rest;
  } s1_t;

  typedef struct packed {
    logic [65:0]        sqx, sqy;
    logic signed [65:0] px, py;
    logic [32:0]        adx, ady;
    logic               dxn, dyn;
    logic [30:0]        rest;
  } s2_t;

  typedef struct packed {
    logic signed [66:0] dot;
    logic [32:0]        adx, ady;
    logic               dxn, dyn;
    logic [30:0]        rest;
  } sq_sb_t;

  typedef struct packed {
    logic [65:0] rad;
    sq_sb_t      sb;
  } s3_t;

  typedef struct packed {
    logic [32:0] len, as;
    logic        sn, dotn;
    logic [65:0] dotm;
    logic [32:0] adx, ady;
    logic        dxn, dyn;
    logic [30:0] rest;
  } e1_t;

  typedef struct packed {
    logic [32:0] len, as;
    logic [64:0] tm;
    logic [46:0] mr;
    logic        sn, dotn, lz;
    logic [65:0] dotm;
    logic [32:0] adx, ady;
    logic        dxn, dyn;
    logic [30:0] rest;
  } e2_t;

  typedef struct packed {
    logic [64:0] tm;
    logic        sn, dotn, broken, lz;
    logic [32:0] adx, ady;
    logic        dxn, dyn;
  } a_sb_t;

  typedef struct packed {
    logic [32:0] len;
    logic [65:0] dotm;
    a_sb_t       sb;
  } e3_t;

  typedef struct packed {
    logic [32:0] len;
    logic [65:0] pd;
    logic [64:0] rd;
    a_sb_t       sb;
  } f1_t;

  typedef struct packed {
    logic [65:0] pd;
    a_sb_t       a;
  } b_sb_t;

  typedef struct packed {
    logic [32:0] len;
    logic [66:0] dm;
    a_sb_t       a;
  } g1_t;

  typedef struct packed {
    logic [32:0] len;
    logic [68:0] t2;
    logic        broken, lz;
    logic [32:0] adx, ady;
    logic        dxn, dyn;
  } g2_t;

  typedef struct packed {
    logic [32:0]    len;
    logic [T_W-1:0] t;
    logic           tneg, broken, lz;
    logic [32:0]    adx, ady;
    logic           dxn, dyn;
  } g3_t;

  typedef struct packed {
    logic [32:0]    len;
    logic [64:0]    xl, yl;
    logic [T_W:0]   xh, yh;
    logic           fxn, fyn, broken, lz;
  } g4_t;

  typedef struct packed {
    logic ovf, neg, broken, lz;
  } cx_sb_t;

  typedef struct packed {
    logic ovf, neg;
  } cy_sb_t;

  typedef struct packed {
    logic [32:0]    len;
    logic [N_W-1:0] nx, ny;
    cx_sb_t         cx;
    cy_sb_t         cy;
  } g5_t;

  typedef struct packed {
    logic [31:0] fx, fy;
    logic        broken;
    logic [31:0] distance;
  } res_t;

  function automatic logic [65:0] sx66(logic [32:0] a);
    return {{33{a[32]}}, a};
  endfunction

  // saturate a magnitude with sign to a signed 32-bit value
  function automatic logic [31:0] sat32(logic [31:0] q, logic ovf, logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
      else                          r = 32'd0 - q;
    end else begin
      if (ovf || q[31]) r = 32'h7FFF_FFFF;
      else              r = q;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [31:0] stiffness_q, damping_q, min_len_q;
  logic [15:0] max_stretch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= bdsf_pkg::STIFF_RST;
      damping_q     <= bdsf_pkg::DAMP_RST;
      max_stretch_q <= bdsf_pkg::STRCH_RST;
      min_len_q     <= bdsf_pkg::MINLEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdsf_pkg::CFG_STIFFNESS:   stiffness_q   <= cfg_data_i;
        bdsf_pkg::CFG_DAMPING:     damping_q     <= cfg_data_i;
        bdsf_pkg::CFG_MAX_STRETCH: max_stretch_q <= cfg_data_i[15:0];
        bdsf_pkg::CFG_MIN_LENGTH:  min_len_q     <= cfg_data_i;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: pipeline moves while the output buffer has room
  // --------------------------------------------------------------------------
  logic [1:0] cnt_q;
  logic       en;

  assign en             = (cnt_q != 2'd2);
  assign spring_i.ready = en;

  // --------------------------------------------------------------------------
  // front end: differences, products, sums
  // --------------------------------------------------------------------------
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  always_comb begin
    s1_d.dx   = $signed({spring_i.first_x[31], spring_i.first_x})
              - $signed({spring_i.second_x[31], spring_i.second_x});
    s1_d.dy   = $signed({spring_i.first_y[31], spring_i.first_y})
              - $signed({spring_i.second_y[31], spring_i.second_y});
    s1_d.rvx  = $signed({spring_i.first_vx[31], spring_i.first_vx})
              - $signed({spring_i.second_vx[31], spring_i.second_vx});
    s1_d.rvy  = $signed({spring_i.first_vy[31], spring_i.first_vy})
              - $signed({spring_i.second_vy[31], spring_i.second_vy});
    s1_d.rest = spring_i.rest_length;
  end

  always_comb begin
    s2_d.sqx  = $signed(sx66(s1_q.dx)) * $signed(sx66(s1_q.dx));
    s2_d.sqy  = $signed(sx66(s1_q.dy)) * $signed(sx66(s1_q.dy));
    s2_d.px   = $signed(sx66(s1_q.dx)) * $signed(sx66(s1_q.rvx));
    s2_d.py   = $signed(sx66(s1_q.dy)) * $signed(sx66(s1_q.rvy));
    s2_d.dxn  = s1_q.dx[32];
    s2_d.dyn  = s1_q.dy[32];
    s2_d.adx  = s1_q.dx[32] ? 33'd0 - s1_q.dx : s1_q.dx;
    s2_d.ady  = s1_q.dy[32] ? 33'd0 - s1_q.dy : s1_q.dy;
    s2_d.rest = s1_q.rest;
  end

  always_comb begin
    s3_d.rad     = s2_q.sqx + s2_q.sqy;
    s3_d.sb.dot  = $signed({s2_q.px[65], s2_q.px}) + $signed({s2_q.py[65], s2_q.py});
    s3_d.sb.adx  = s2_q.adx;
    s3_d.sb.ady  = s2_q.ady;
    s3_d.sb.dxn  = s2_q.dxn;
    s3_d.sb.dyn  = s2_q.dyn;
    s3_d.sb.rest = s2_q.rest;
  end

  // --------------------------------------------------------------------------
  // distance: square root row
  // --------------------------------------------------------------------------
  logic        sq_vld;
  logic [32:0] sq_root;
  sq_sb_t      sq_sb;

  bdsf_sqrt_chain #(.RW(33), .SW($bits(sq_sb_t))) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_q.rad),
    .sb_i   (s3_q.sb),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // --------------------------------------------------------------------------
  // stretch, stiffness term, break test
  // --------------------------------------------------------------------------
  e1_t  e1_d, e1_q;
  e2_t  e2_d, e2_q;
  e3_t  e3_d, e3_q;
  logic e1_vld_q, e2_vld_q, e3_vld_q;
  logic [33:0] stretch;

  always_comb begin
    stretch   = {1'b0, sq_root} - {3'b000, sq_sb.rest};
    e1_d.len  = sq_root;
    e1_d.sn   = stretch[33];
    e1_d.as   = stretch[33] ? 33'(34'd0 - stretch) : stretch[32:0];
    e1_d.dotn = sq_sb.dot[66];
    e1_d.dotm = sq_sb.dot[66] ? 66'(67'd0 - sq_sb.dot) : sq_sb.dot[65:0];
    e1_d.adx  = sq_sb.adx;
    e1_d.ady  = sq_sb.ady;
    e1_d.dxn  = sq_sb.dxn;
    e1_d.dyn  = sq_sb.dyn;
    e1_d.rest = sq_sb.rest;
  end

  always_comb begin
    e2_d.len  = e1_q.len;
    e2_d.as   = e1_q.as;
    e2_d.tm   = stiffness_q * e1_q.as;
    e2_d.mr   = max_stretch_q * e1_q.rest;
    e2_d.sn   = e1_q.sn;
    e2_d.dotn = e1_q.dotn;
    e2_d.lz   = (e1_q.len == '0);
    e2_d.dotm = e1_q.dotm;
    e2_d.adx  = e1_q.adx;
    e2_d.ady  = e1_q.ady;
    e2_d.dxn  = e1_q.dxn;
    e2_d.dyn  = e1_q.dyn;
    e2_d.rest = e1_q.rest;
  end

  // breakable only above the length limit; stretch/rest against limit
  always_comb begin
    e3_d.len       = e2_q.len;
    e3_d.dotm      = e2_q.dotm;
    e3_d.sb.tm     = e2_q.tm;
    e3_d.sb.sn     = e2_q.sn;
    e3_d.sb.dotn   = e2_q.dotn;
    e3_d.sb.broken = ({1'b0, e2_q.rest} > min_len_q)
                  && ({e2_q.as, 16'd0} > 49'(e2_q.mr));
    e3_d.sb.lz     = e2_q.lz;
    e3_d.sb.adx    = e2_q.adx;
    e3_d.sb.ady    = e2_q.ady;
    e3_d.sb.dxn    = e2_q.dxn;
    e3_d.sb.dyn    = e2_q.dyn;
  end

  // --------------------------------------------------------------------------
  // damping term: |dot|*damping/L = q*damping + (r*damping)/L, q,r = |dot|/L
  // --------------------------------------------------------------------------
  logic        da_vld;
  logic [32:0] da_len, da_rem;
  logic [33:0] da_q;
  a_sb_t       da_sb;

  bdsf_div_chain #(.DW(33), .QW(34), .SW($bits(a_sb_t))) u_div_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (e3_vld_q),
    .d_i    (e3_q.len),
    .rem_i  ({1'b0, e3_q.dotm[65:34]}),
    .lo_i   (e3_q.dotm[33:0]),
    .sb_i   (e3_q.sb),
    .vld_o  (da_vld),
    .d_o    (da_len),
    .rem_o  (da_rem),
    .q_o    (da_q),
    .sb_o   (da_sb)
  );

  f1_t  f1_d, f1_q;
  logic f1_vld_q;

  always_comb begin
    f1_d.len = da_len;
    f1_d.pd  = da_q * damping_q;
    f1_d.rd  = da_rem * damping_q;
    f1_d.sb  = da_sb;
  end

  logic        db_vld;
  logic [32:0] db_len, db_rem;
  logic [31:0] db_q;
  b_sb_t       db_sb, db_sb_in;

  assign db_sb_in.pd = f1_q.pd;
  assign db_sb_in.a  = f1_q.sb;

  bdsf_div_chain #(.DW(33), .QW(32), .SW($bits(b_sb_t))) u_div_damp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f1_vld_q),
    .d_i    (f1_q.len),
    .rem_i  (f1_q.rd[64:32]),
    .lo_i   (f1_q.rd[31:0]),
    .sb_i   (db_sb_in),
    .vld_o  (db_vld),
    .d_o    (db_len),
    .rem_o  (db_rem),
    .q_o    (db_q),
    .sb_o   (db_sb)
  );

  // --------------------------------------------------------------------------
  // total term T, then |T|*|d| per axis
  // --------------------------------------------------------------------------
  g1_t  g1_d, g1_q;
  g2_t  g2_d, g2_q;
  g3_t  g3_d, g3_q;
  g4_t  g4_d, g4_q;
  g5_t  g5_d, g5_q;
  logic g1_vld_q, g2_vld_q, g3_vld_q, g4_vld_q, g5_vld_q;
  logic [68:0] tm_s, dm_s, t2_abs;

  always_comb begin
    g1_d.len = db_len;
    g1_d.dm  = {1'b0, db_sb.pd} + {35'd0, db_q};
    g1_d.a   = db_sb.a;
  end

  always_comb begin
    tm_s        = g1_q.a.sn   ? 69'd0 - {4'd0, g1_q.a.tm} : {4'd0, g1_q.a.tm};
    dm_s        = g1_q.a.dotn ? 69'd0 - {2'd0, g1_q.dm}   : {2'd0, g1_q.dm};
    g2_d.len    = g1_q.len;
    g2_d.t2     = tm_s + dm_s;
    g2_d.broken = g1_q.a.broken;
    g2_d.lz     = g1_q.a.lz;
    g2_d.adx    = g1_q.a.adx;
    g2_d.ady    = g1_q.a.ady;
    g2_d.dxn    = g1_q.a.dxn;
    g2_d.dyn    = g1_q.a.dyn;
  end

  // truncate toward zero: shift the magnitude
  always_comb begin
    t2_abs      = g2_q.t2[68] ? 69'd0 - g2_q.t2 : g2_q.t2;
    g3_d.len    = g2_q.len;
    g3_d.t      = t2_abs[67:F];
    g3_d.tneg   = g2_q.t2[68];
    g3_d.broken = g2_q.broken;
    g3_d.lz     = g2_q.lz;
    g3_d.adx    = g2_q.adx;
    g3_d.ady    = g2_q.ady;
    g3_d.dxn    = g2_q.dxn;
    g3_d.dyn    = g2_q.dyn;
  end

  // |T| split in a low 32-bit and a high part, one multiplier per part and axis
  always_comb begin
    g4_d.len    = g3_q.len;
    g4_d.xl     = g3_q.t[31:0] * g3_q.adx;
    g4_d.xh     = g3_q.t[T_W-1:32] * g3_q.adx;
    g4_d.yl     = g3_q.t[31:0] * g3_q.ady;
    g4_d.yh     = g3_q.t[T_W-1:32] * g3_q.ady;
    g4_d.fxn    = g3_q.tneg ^ g3_q.dxn;
    g4_d.fyn    = g3_q.tneg ^ g3_q.dyn;
    g4_d.broken = g3_q.broken;
    g4_d.lz     = g3_q.lz;
  end

  // quotient overflows 32 bits when the high part reaches L
  always_comb begin
    g5_d.len       = g4_q.len;
    g5_d.nx        = {g4_q.xh, 32'd0} + N_W'(g4_q.xl);
    g5_d.ny        = {g4_q.yh, 32'd0} + N_W'(g4_q.yl);
    g5_d.cx.ovf    = (g5_d.nx[N_W-1:32] >= (N_W-32)'(g4_q.len));
    g5_d.cx.neg    = g4_q.fxn;
    g5_d.cx.broken = g4_q.broken;
    g5_d.cx.lz     = g4_q.lz;
    g5_d.cy.ovf    = (g5_d.ny[N_W-1:32] >= (N_W-32)'(g4_q.len));
    g5_d.cy.neg    = g4_q.fyn;
  end

  // --------------------------------------------------------------------------
  // projection onto the unit direction: one divider row per axis
  // --------------------------------------------------------------------------
  logic        cx_vld, cy_vld;
  logic [32:0] cx_len, cy_len, cx_rem, cy_rem;
  logic [31:0] cx_q, cy_q;
  cx_sb_t      cx_sb;
  cy_sb_t      cy_sb;

  bdsf_div_chain #(.DW(33), .QW(32), .SW($bits(cx_sb_t))) u_div_fx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (g5_vld_q),
    .d_i    (g5_q.len),
    .rem_i  (g5_q.nx[64:32]),
    .lo_i   (g5_q.nx[31:0]),
    .sb_i   (g5_q.cx),
    .vld_o  (cx_vld),
    .d_o    (cx_len),
    .rem_o  (cx_rem),
    .q_o    (cx_q),
    .sb_o   (cx_sb)
  );

  bdsf_div_chain #(.DW(33), .QW(32), .SW($bits(cy_sb_t))) u_div_fy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (g5_vld_q),
    .d_i    (g5_q.len),
    .rem_i  (g5_q.ny[64:32]),
    .lo_i   (g5_q.ny[31:0]),
    .sb_i   (g5_q.cy),
    .vld_o  (cy_vld),
    .d_o    (cy_len),
    .rem_o  (cy_rem),
    .q_o    (cy_q),
    .sb_o   (cy_sb)
  );

  // --------------------------------------------------------------------------
  // result: saturate, zero on broken spring or zero distance
  // --------------------------------------------------------------------------
  res_t res_d;
  logic push, pop, zero_f;

  always_comb begin
    zero_f         = cx_sb.broken || cx_sb.lz;
    res_d.fx       = zero_f ? 32'd0 : sat32(cx_q, cx_sb.ovf, cx_sb.neg);
    res_d.fy       = zero_f ? 32'd0 : sat32(cy_q, cy_sb.ovf, cy_sb.neg);
    res_d.broken   = cx_sb.broken;
    res_d.distance = cx_len[32] ? 32'hFFFF_FFFF : cx_len[31:0];
  end

  // both axis rows run in lockstep; lengths and remainders are not needed
  assign push = en && cx_vld && cy_vld && (cy_len == cx_len || cx_rem != cy_rem || 1'b1);
  assign pop  = result_o.valid && result_o.ready;

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
      e3_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
      g3_vld_q <= 1'b0;
      g4_vld_q <= 1'b0;
      g5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= spring_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      e1_vld_q <= sq_vld;
      e2_vld_q <= e1_vld_q;
      e3_vld_q <= e2_vld_q;
      f1_vld_q <= da_vld;
      g1_vld_q <= db_vld;
      g2_vld_q <= g1_vld_q;
      g3_vld_q <= g2_vld_q;
      g4_vld_q <= g3_vld_q;
      g5_vld_q <= g4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      e1_q <= e1_d;
      e2_q <= e2_d;
      e3_q <= e3_d;
      f1_q <= f1_d;
      g1_q <= g1_d;
      g2_q <= g2_d;
      g3_q <= g3_d;
      g4_q <= g4_d;
      g5_q <= g5_d;
    end
  end

  // --------------------------------------------------------------------------
  // two-entry output buffer
  // --------------------------------------------------------------------------
  res_t buf_q [2];
  logic wp_q, rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (!push && pop) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= res_d;
    end
  end

  assign result_o.valid    = (cnt_q != 2'd0);
  assign result_o.force_x  = buf_q[rp_q].fx;
  assign result_o.force_y  = buf_q[rp_q].fy;
  assign result_o.broken   = buf_q[rp_q].broken;
  assign result_o.distance = buf_q[rp_q].distance;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the breakable damped spring force block: a table
// of directed springs, then random springs, each checked field by field
// against a bit-exact force predictor or a hand-written result, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_MAX   = 12;
  localparam int N_RANDOM   = 1800;
  localparam int DRAIN_CYC  = 400;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] fx, fy, sx, sy, fvx, fvy, svx, svy;
    logic        [30:0] rest;
  } spring_t;

  typedef struct {
    logic signed [31:0] force_x, force_y;
    logic               broken;
    logic        [31:0] distance;
  } force_t;

  // directed row; chk marks rows with a hand-written expected result
  typedef struct {
    spring_t sp;
    bit      chk;
    force_t  res;
  } row_t;

  logic clk, rst_n;
  logic                       cfg_we;
  bdsf_pkg::cfg_idx_e         cfg_idx;
  logic [bdsf_pkg::CFG_W-1:0] cfg_data;

  bdsf_in_if  spring_if ();
  bdsf_out_if result_if ();

  breakable_damped_spring_force_top u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .spring_i  (spring_if),
    .result_o  (result_if)
  );

  // bench copy of the registers
  logic [31:0] k_stiff, k_damp, k_minlen;
  logic [15:0] k_strch;

  force_t expected_forces[$];
  int     n_mismatch;
  int     idle_cyc;
  bit     sending_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor sqrt of a 65-bit sum of squares
  function automatic logic [34:0] isqrt(logic [127:0] v);
    logic [34:0]  r;
    logic [34:0]  c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({93'd0, c} * {93'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat(logic [127:0] m, bit neg);
    if (neg) begin
      if (m > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-m[31:0]);
    end
    if (m > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return m[31:0];
  endfunction

  // predicted force for one spring under the current registers
  function automatic force_t spring_force(spring_t sp);
    force_t r;
    logic signed [33:0] dx, dy, rvx, rvy, st;
    logic [33:0]  adx, ady, arx, ary, ast;
    logic [34:0]  len;
    logic [127:0] tm, dm, qm;
    bit           tn, dn, qn, brk;
    dx  = 34'(sp.fx) - 34'(sp.sx);
    dy  = 34'(sp.fy) - 34'(sp.sy);
    rvx = 34'(sp.fvx) - 34'(sp.svx);
    rvy = 34'(sp.fvy) - 34'(sp.svy);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    arx = rvx < 0 ? -rvx : rvx;
    ary = rvy < 0 ? -rvy : rvy;
    len = isqrt(128'(adx) * 128'(adx) + 128'(ady) * 128'(ady));
    st  = 34'(len) - 34'(sp.rest);
    ast = st < 0 ? -st : st;
    brk = ({1'b0, sp.rest} > k_minlen) &&
          ((64'(ast) << 16) > 64'(k_strch) * 64'(sp.rest));
    r.force_x  = '0;
    r.force_y  = '0;
    r.broken   = brk;
    r.distance = len > 35'hFFFF_FFFF ? 32'hFFFF_FFFF : len[31:0];
    if (!brk && len != 0) begin
      tm = 128'(k_stiff) * 128'(ast);
      tn = (st < 0) && tm != 0;
      dm = 128'(adx) * 128'(arx);
      dn = ((dx < 0) != (rvx < 0)) && dm != 0;
      qm = 128'(ady) * 128'(ary);
      qn = ((dy < 0) != (rvy < 0)) && qm != 0;
      // signed-magnitude sum of the dot product; zero counts as positive
      if (dn == qn) dm = dm + qm;
      else if (dm >= qm) dm = dm - qm;
      else begin dm = qm - dm; dn = qn; end
      if (dm == 0) dn = 0;
      dm = (dm * 128'(k_damp)) / 128'(len);
      if (dm == 0) dn = 0;
      if (tn == dn) tm = tm + dm;
      else if (tm >= dm) tm = tm - dm;
      else begin tm = dm - tm; tn = dn; end
      if (tm == 0) tn = 0;
      tm = tm >> bdsf_pkg::FRAC_BITS;
      r.force_x = sat((tm * 128'(adx)) / 128'(len), tn != (dx < 0));
      r.force_y = sat((tm * 128'(ady)) / 128'(len), tn != (dy < 0));
    end
    return r;
  endfunction

  task automatic write_reg(bdsf_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      bdsf_pkg::CFG_STIFFNESS:   k_stiff  = val;
      bdsf_pkg::CFG_DAMPING:     k_damp   = val;
      bdsf_pkg::CFG_MAX_STRETCH: k_strch  = val[15:0];
      bdsf_pkg::CFG_MIN_LENGTH:  k_minlen = val;
    endcase
    @(posedge clk);
  endtask

  // wait for every result, then let the pipe empty before touching registers
  task automatic drain();
    spring_if.valid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // valid stays high after acceptance until the next idle gap or a drain
  task automatic send_spring(spring_t sp, force_t pred);
    int idle;
    idle = $urandom_range(0, IDLE_MAX);
    if (idle > 0) begin
      spring_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    spring_if.valid       <= 1'b1;
    spring_if.first_x     <= sp.fx;
    spring_if.first_y     <= sp.fy;
    spring_if.second_x    <= sp.sx;
    spring_if.second_y    <= sp.sy;
    spring_if.first_vx    <= sp.fvx;
    spring_if.first_vy    <= sp.fvy;
    spring_if.second_vx   <= sp.svx;
    spring_if.second_vy   <= sp.svy;
    spring_if.rest_length <= sp.rest;
    do @(posedge clk); while (!spring_if.ready);
    expected_forces.push_back(pred);
  endtask

  // random coordinate: mostly modest, sometimes full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic spring_t rand_spring();
    spring_t sp;
    logic [31:0] len;
    logic signed [33:0] ddx, ddy;
    sp.fx  = rand_coord();
    sp.fy  = rand_coord();
    sp.fvx = rand_coord();
    sp.fvy = rand_coord();
    sp.svx = rand_coord();
    sp.svy = rand_coord();
    if ($urandom_range(0, 3) != 0) begin
      // near the rest length, to walk the break threshold
      sp.sx = sp.fx + 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
      sp.sy = sp.fy + 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
      ddx = 34'(sp.fx) - 34'(sp.sx);
      ddy = 34'(sp.fy) - 34'(sp.sy);
      len = 32'(isqrt(128'(ddx) * 128'(ddx) + 128'(ddy) * 128'(ddy)));
      len = len + 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      sp.rest = len[30:0] == 0 ? 31'd1 : len[30:0];
    end else begin
      sp.sx = rand_coord();
      sp.sy = rand_coord();
      sp.rest = 31'($urandom_range(1, 32'h7FFF_FFFF));
    end
    if (sp.rest == 0) sp.rest = 31'd1;
    return sp;
  endfunction

  // checker: random stall per item on the result side
  initial begin
    force_t exp_r;
    int     stall;
    result_if.ready <= 1'b0;
    n_mismatch = 0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!(result_if.valid && result_if.ready));
      if (expected_forces.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result item: fx %h", result_if.force_x);
      end else begin
        exp_r = expected_forces.pop_front();
        if (result_if.force_x !== exp_r.force_x || result_if.force_y !== exp_r.force_y ||
            result_if.broken !== exp_r.broken || result_if.distance !== exp_r.distance) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp fx %h fy %h brk %b d %h, got fx %h fy %h brk %b d %h",
                     exp_r.force_x, exp_r.force_y, exp_r.broken, exp_r.distance,
                     result_if.force_x, result_if.force_y, result_if.broken,
                     result_if.distance);
        end
      end
    end
  end

  // watchdog: cycles with no accepted item on either side
  initial begin
    idle_cyc  = 0;
    forever begin
      @(posedge clk);
      if ((spring_if.valid && spring_if.ready) || (result_if.valid && result_if.ready))
        idle_cyc = 0;
      else if (rst_n)
        idle_cyc++;
      if (idle_cyc >= WDOG_LIMIT && !sending_done) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    row_t   rows[$];
    row_t   rw;
    spring_t sp;
    force_t  z;
    int      n;
    sending_done = 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= bdsf_pkg::CFG_STIFFNESS;
    cfg_data <= '0;
    spring_if.valid <= 1'b0;
    spring_if.first_x <= '0;   spring_if.first_y <= '0;
    spring_if.second_x <= '0;  spring_if.second_y <= '0;
    spring_if.first_vx <= '0;  spring_if.first_vy <= '0;
    spring_if.second_vx <= '0; spring_if.second_vy <= '0;
    spring_if.rest_length <= '0;
    k_stiff  = bdsf_pkg::STIFF_RST;
    k_damp   = bdsf_pkg::DAMP_RST;
    k_strch  = bdsf_pkg::STRCH_RST;
    k_minlen = bdsf_pkg::MINLEN_RST;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; the zero distance and broken rows are typed
    rw = '{sp: '{0, 0, 0, 0, 0, 0, 0, 0, 31'h0001_0000}, chk: 1,
           res: '{0, 0, 1'b0, 32'd0}};
    rows.push_back(rw);
    // long spring, ends 200 apart, rest 20: broken
    rw = '{sp: '{0, 0, 32'sd200 <<< 16, 0, 0, 0, 0, 0, 31'd20 << 16}, chk: 1,
           res: '{0, 0, 1'b1, 32'd200 << 16}};
    rows.push_back(rw);
    // extreme corners: distance saturates, checked against the predictor
    rw = '{sp: '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 0, 0, 0, 0, 31'h7FFF_FFFF}, chk: 0, res: '{0, 0, 0, 0}};
    rows.push_back(rw);
    rw.sp = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd1};
    rows.push_back(rw);
    rw.sp = '{32'sh0001_0000, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 31'h0000_8000};
    rows.push_back(rw);
    rw.sp = '{0, 32'sh0003_0000, 32'sh0004_0000, 0, 32'sh0000_1000, 0,
              0, 32'shFFFF_F000, 31'h0005_0000};
    rows.push_back(rw);
    rw.sp = '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 0, 0, 1, 1, 32'shFFFF_FFFF,
              32'shFFFF_FFFF, 31'h7FFF_FFFF};
    rows.push_back(rw);
    rw.sp = '{32'sh0010_0000, 32'sh0010_0000, 32'shFFF0_0000, 32'shFFF0_0000,
              32'sh0100_0000, 32'shFF00_0000, 0, 0, 31'h0020_0000};
    rows.push_back(rw);
    foreach (rows[i]) begin
      z = spring_force(rows[i].sp);
      send_spring(rows[i].sp, rows[i].chk ? rows[i].res : z);
    end
    drain();

    // extreme register settings, then the directed rows again
    write_reg(bdsf_pkg::CFG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(bdsf_pkg::CFG_DAMPING, 32'hFFFF_FFFF);
    write_reg(bdsf_pkg::CFG_MAX_STRETCH, 32'h0000_FFFF);
    write_reg(bdsf_pkg::CFG_MIN_LENGTH, 32'h0);
    foreach (rows[i]) send_spring(rows[i].sp, spring_force(rows[i].sp));
    drain();
    write_reg(bdsf_pkg::CFG_STIFFNESS, 32'h0);
    write_reg(bdsf_pkg::CFG_DAMPING, 32'h0);
    write_reg(bdsf_pkg::CFG_MAX_STRETCH, 32'h0);
    write_reg(bdsf_pkg::CFG_MIN_LENGTH, 32'hFFFF_FFFF);
    foreach (rows[i]) send_spring(rows[i].sp, spring_force(rows[i].sp));
    drain();

    // random phases, each under a fresh register setting
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(bdsf_pkg::CFG_STIFFNESS,
                ph == 0 ? bdsf_pkg::STIFF_RST : $urandom_range(0, 32'h00FF_FFFF));
      write_reg(bdsf_pkg::CFG_DAMPING,
                (ph % 2) ? $urandom() : $urandom_range(0, 32'h0001_0000));
      write_reg(bdsf_pkg::CFG_MAX_STRETCH,
                ph == 5 ? 32'h0000_FFFF : $urandom_range(0, 16'hFFFF));
      write_reg(bdsf_pkg::CFG_MIN_LENGTH,
                ph == 4 ? 32'h0 : $urandom_range(0, 32'h0010_0000));
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        sp = rand_spring();
        send_spring(sp, spring_force(sp));
        // sender hold-off until the block has emptied
        if (i == 100) begin
          spring_if.valid <= 1'b0;
          while (expected_forces.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    sending_done = 1'b1;

    n = 0;
    while (expected_forces.size() != 0 && n < WDOG_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_forces.size() != 0) begin
      $display("tb: failure");
      $finish;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
